// ===== hw/rtl/causal_multihead_attention_assert.svh =====
// assertion macros for the causal attention block
// expects clk_i and rst_ni in the scope of each use
`ifndef CAUSAL_MULTIHEAD_ATTENTION_ASSERT_SVH
`define CAUSAL_MULTIHEAD_ATTENTION_ASSERT_SVH

// same-cycle implication
`define CMHA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmha assertion failed");

// next-cycle implication
`define CMHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmha assertion failed");

`endif

// ===== hw/rtl/cmha_pkg.sv =====
// shared constants and helpers for the causal attention block
// no dependencies
`default_nettype none

package cmha_pkg;

  localparam int TOK_W       = 8;
  localparam int SLOTS       = 256;
  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int DATA_W      = 16;
  localparam int SCORE_W     = 48;
  localparam int ACC_W       = 48;
  localparam int MA_W        = 40;
  localparam int MB_W        = 18;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int EXP_W       = 17;
  localparam int SUM_W       = 25;
  localparam int NUM_W       = 34;
  localparam int Q_W         = 17;
  localparam int QCNT_W      = 5;

  localparam int LOG2E_Q16 = 94548;
  localparam int EXP_C1    = 43024;
  localparam int EXP_C2    = 22512;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // integer square root, used at elaboration only
  function automatic logic [15:0] isqrt32(input logic [31:0] x);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] bit_v;
    rem   = x;
    root  = '0;
    bit_v = 32'h4000_0000;
    for (int i = 0; i < 16; i++) begin
      if (rem >= root + bit_v) begin
        rem  = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cmha_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module cmha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cmha_mul.sv =====
// shared signed multiplier with registered product
// depends on cmha_pkg
`default_nettype none

module cmha_mul
  import cmha_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [MA_W-1:0]   a_i,
  input  wire logic signed [MB_W-1:0]   b_i,
  output      logic signed [PROD_W-1:0] p_o
);

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cmha_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on cmha_pkg; needs num_i < den_i * 2^Q_W
`default_nettype none

module cmha_div
  import cmha_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [SUM_W-1:0] den_i,
  output      logic             done_o,
  output      logic [Q_W-1:0]   quo_o
);

  logic              run_q;
  logic              done_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]  rem_q;
  logic [SUM_W-1:0]  rem_n;
  logic [Q_W-1:0]    quo_q;
  logic [SUM_W:0]    trial;
  logic              qbit;

  // trial subtract
  always_comb begin
    trial = {rem_q, quo_q[Q_W-1]};
    qbit  = (trial >= {1'b0, den_i});
    rem_n = qbit ? SUM_W'(trial - {1'b0, den_i}) : trial[SUM_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= QCNT_W'(Q_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == QCNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SUM_W'(num_i[NUM_W-1:Q_W]);
      quo_q <= num_i[Q_W-1:0];
    end else if (run_q) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[Q_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/causal_multihead_attention.sv =====
// causal scaled dot-product attention, one query token and head per compute
// depends on cmha_pkg, cmha_ram, cmha_mul, cmha_div, assertion macro header
//
//   channel  direction  handshake                 payload
//   command  in         start & !busy             command, token/element/head, q/k/v
//   result   out        result_valid_o one cycle  context_value, dim_index, last
//
// a load never raises busy; the length of a compute grows with its query
// token t and is set by the single shared multiplier, one read port per
// store and the one-bit-per-cycle divider. busy stays high from acceptance
// of a compute until its last result has been registered. results cannot
// be stalled. reset is asynchronous, active low, and clears only the
// control registers.
`default_nettype none
`include "causal_multihead_attention_assert.svh"

module causal_multihead_attention
  import cmha_pkg::*;
#(
  parameter int MAX_TOKENS   = 256,
  parameter int HEADS        = 4,
  parameter int DIM_PER_HEAD = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic               command_i,
  input  wire logic [7:0]         token_index_i,
  input  wire logic [7:0]         element_index_i,
  input  wire logic [1:0]         head_index_i,
  input  wire logic signed [15:0] query_value_i,
  input  wire logic signed [15:0] key_value_i,
  input  wire logic signed [15:0] value_value_i,
  output      logic               result_valid_o,
  output      logic signed [15:0] context_value_o,
  output      logic [5:0]         dim_index_o,
  output      logic               last_o
);

  localparam int              DW        = $clog2(DIM_PER_HEAD);
  localparam logic [DW-1:0]   D_LAST    = DW'(DIM_PER_HEAD - 1);
  localparam logic [7:0]      HD8       = 8'(DIM_PER_HEAD);
  localparam logic [31:0]     RECIP_ARG = 32'((64'd1 << 32) / DIM_PER_HEAD);
  localparam logic [15:0]     RECIP     = isqrt32(RECIP_ARG);
  localparam logic signed [PROD_W-1:0] RND16   = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] EXP_LIM = -PROD_W'(1048576);

  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_DOT      = 17'b00000000000000010,
    S_DOTW     = 17'b00000000000000100,
    S_SCALE    = 17'b00000000000001000,
    S_SCALE2   = 17'b00000000000010000,
    S_EXP_RD   = 17'b00000000000100000,
    S_EXP_M1   = 17'b00000000001000000,
    S_EXP_M2   = 17'b00000000010000000,
    S_EXP_M3   = 17'b00000000100000000,
    S_EXP_M4   = 17'b00000001000000000,
    S_EXP_M5   = 17'b00000010000000000,
    S_NRM_RD   = 17'b00000100000000000,
    S_NRM_DIV  = 17'b00001000000000000,
    S_NRM_WAIT = 17'b00010000000000000,
    S_CTX      = 17'b00100000000000000,
    S_CTXW     = 17'b01000000000000000,
    S_CTX_OUT  = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0]    tok_q, tok_d, j_q, j_d;
  logic [1:0]    head_q, head_d;
  logic [DW-1:0] d_q, d_d;
  logic          ctx_q, ctx_d;
  logic signed [SCORE_W-1:0] max_q, max_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [15:0]   f_q, f_d;
  logic [4:0]    k_q, k_d;
  logic          ez_q, ez_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  // mac pipeline tags
  logic issue, issue_first, issue_last;
  logic p1_vld_q, p1_first_q, p1_last_q;
  logic p2_vld_q, p2_first_q, p2_last_q;
  logic done_q;

  logic               res_vld_q, res_vld_d;
  logic signed [15:0] cval_q, cval_d;
  logic [5:0]         dim_q, dim_d;
  logic               last_q, last_d;

  logic acc_in, load_ok, comp_ok;
  logic [7:0] elem;

  logic [STORE_AW-1:0] q_addr, k_addr, v_addr;
  logic [DATA_W-1:0]   q_rd, k_rd, v_rd;
  logic                sb_we;
  logic [SCORE_W-1:0]  sb_wdata, sb_rd;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [Q_W-1:0]   div_quo;

  logic signed [PROD_W-1:0]  rnd_p, neg_n;
  logic signed [SCORE_W-1:0] score, diff;
  logic [EXP_W-1:0] t_c, p_e, e_v;
  logic [15:0]      w_v;
  logic signed [ACC_W-1:0] c_full;
  logic signed [15:0]      c_sat;

  // transaction acceptance
  assign busy    = (state_q != S_IDLE);
  assign acc_in  = start && !busy;
  assign load_ok = acc_in && (command_i == CMD_LOAD)
                   && (int'(token_index_i) < MAX_TOKENS)
                   && (int'(element_index_i) < HEADS * DIM_PER_HEAD);
  assign comp_ok = acc_in && (command_i == CMD_COMPUTE)
                   && (int'(head_index_i) < HEADS)
                   && (int'(token_index_i) < MAX_TOKENS);

  // hidden position of the current head dimension
  assign elem = 8'(head_q) * HD8 + 8'(d_q);

  // store addressing: loads in idle, walks otherwise
  always_comb begin
    if (!busy) begin
      q_addr = {token_index_i, element_index_i};
      k_addr = {token_index_i, element_index_i};
      v_addr = {token_index_i, element_index_i};
    end else begin
      q_addr = {tok_q, elem};
      k_addr = {j_q, elem};
      v_addr = {j_q, elem};
    end
  end

  cmha_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_qstore (
    .clk_i, .we_i(load_ok), .addr_i(q_addr),
    .wdata_i(query_value_i), .rdata_o(q_rd)
  );
  cmha_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_kstore (
    .clk_i, .we_i(load_ok), .addr_i(k_addr),
    .wdata_i(key_value_i), .rdata_o(k_rd)
  );
  cmha_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_vstore (
    .clk_i, .we_i(load_ok), .addr_i(v_addr),
    .wdata_i(value_value_i), .rdata_o(v_rd)
  );
  cmha_ram #(.WIDTH(SCORE_W), .DEPTH(SLOTS)) u_sbuf (
    .clk_i, .we_i(sb_we), .addr_i(j_q),
    .wdata_i(sb_wdata), .rdata_o(sb_rd)
  );

  // arithmetic on the registered product, score buffer and accumulator
  always_comb begin
    rnd_p  = (mul_p + RND16) >>> 16;
    score  = rnd_p[SCORE_W-1:0];
    diff   = $signed(sb_rd) - max_q;
    neg_n  = -(rnd_p >>> 16);
    t_c    = EXP_W'(EXP_C1) + {1'b0, mul_p[31:16]};
    p_e    = EXP_W'(65536) + {1'b0, mul_p[31:16]};
    e_v    = ez_q ? '0 : (p_e >> k_q);
    div_num = NUM_W'({sb_rd[EXP_W-1:0], 16'b0}) + NUM_W'(sum_q >> 1);
    w_v    = div_quo[Q_W-1] ? 16'hFFFF : div_quo[15:0];
    c_full = (acc_q + ACC_W'(32768)) >>> 16;
    if (c_full > ACC_W'(32767)) begin
      c_sat = 16'sh7FFF;
    end else if (c_full < -ACC_W'(32768)) begin
      c_sat = -16'sh8000;
    end else begin
      c_sat = c_full[15:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    priority if (state_q == S_SCALE) begin
      mul_a = acc_q[MA_W-1:0];
      mul_b = {2'b0, RECIP};
    end else if (state_q == S_EXP_M1) begin
      mul_a = diff[MA_W-1:0];
      mul_b = MB_W'(LOG2E_Q16);
    end else if (state_q == S_EXP_M3) begin
      mul_a = {{(MA_W-16){1'b0}}, f_q};
      mul_b = MB_W'(EXP_C2);
    end else if (state_q == S_EXP_M4) begin
      mul_a = {{(MA_W-16){1'b0}}, f_q};
      mul_b = {1'b0, t_c};
    end else if (ctx_q) begin
      mul_a = MA_W'($signed(v_rd));
      mul_b = {2'b0, sb_rd[15:0]};
    end else begin
      mul_a = MA_W'($signed(q_rd));
      mul_b = MB_W'($signed(k_rd));
    end
  end

  cmha_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  cmha_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(sum_q), .done_o(div_done), .quo_o(div_quo)
  );

  // accumulator
  always_comb begin
    acc_d = acc_q;
    if (p2_vld_q) begin
      acc_d = (p2_first_q ? '0 : acc_q) + mul_p[ACC_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    tok_d       = tok_q;
    head_d      = head_q;
    j_d         = j_q;
    d_d         = d_q;
    ctx_d       = ctx_q;
    max_d       = max_q;
    sum_d       = sum_q;
    f_d         = f_q;
    k_d         = k_q;
    ez_d        = ez_q;
    issue       = 1'b0;
    issue_first = 1'b0;
    issue_last  = 1'b0;
    sb_we       = 1'b0;
    sb_wdata    = '0;
    div_start   = 1'b0;
    res_vld_d   = 1'b0;
    cval_d      = cval_q;
    dim_d       = dim_q;
    last_d      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (comp_ok) begin
          tok_d   = token_index_i;
          head_d  = head_index_i;
          j_d     = '0;
          d_d     = '0;
          ctx_d   = 1'b0;
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        issue       = 1'b1;
        issue_first = (d_q == '0);
        issue_last  = (d_q == D_LAST);
        if (d_q == D_LAST) begin
          d_d     = '0;
          state_d = S_DOTW;
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      S_DOTW: begin
        if (done_q) state_d = S_SCALE;
      end
      S_SCALE: begin
        state_d = S_SCALE2;
      end
      S_SCALE2: begin
        sb_we    = 1'b1;
        sb_wdata = score;
        if ((j_q == '0) || (score > max_q)) max_d = score;
        if (j_q == tok_q) begin
          j_d     = '0;
          sum_d   = '0;
          state_d = S_EXP_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_DOT;
        end
      end
      S_EXP_RD: state_d = S_EXP_M1;
      S_EXP_M1: state_d = S_EXP_M2;
      S_EXP_M2: begin
        f_d     = rnd_p[15:0];
        k_d     = neg_n[4:0];
        ez_d    = (rnd_p < EXP_LIM);
        state_d = S_EXP_M3;
      end
      S_EXP_M3: state_d = S_EXP_M4;
      S_EXP_M4: state_d = S_EXP_M5;
      S_EXP_M5: begin
        sb_we    = 1'b1;
        sb_wdata = SCORE_W'(e_v);
        sum_d    = sum_q + SUM_W'(e_v);
        if (j_q == tok_q) begin
          j_d     = '0;
          state_d = S_NRM_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_EXP_RD;
        end
      end
      S_NRM_RD: state_d = S_NRM_DIV;
      S_NRM_DIV: begin
        div_start = 1'b1;
        state_d   = S_NRM_WAIT;
      end
      S_NRM_WAIT: begin
        if (div_done) begin
          sb_we    = 1'b1;
          sb_wdata = SCORE_W'(w_v);
          if (j_q == tok_q) begin
            j_d     = '0;
            d_d     = '0;
            ctx_d   = 1'b1;
            state_d = S_CTX;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_NRM_RD;
          end
        end
      end
      S_CTX: begin
        issue       = 1'b1;
        issue_first = (j_q == '0);
        issue_last  = (j_q == tok_q);
        if (j_q == tok_q) begin
          j_d     = '0;
          state_d = S_CTXW;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_CTXW: begin
        if (done_q) state_d = S_CTX_OUT;
      end
      S_CTX_OUT: begin
        res_vld_d = 1'b1;
        cval_d    = c_sat;
        dim_d     = 6'(d_q);
        last_d    = (d_q == D_LAST);
        if (d_q == D_LAST) begin
          ctx_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          d_d     = d_q + 1'b1;
          state_d = S_CTX;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      j_q       <= '0;
      d_q       <= '0;
      ctx_q     <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      j_q       <= j_d;
      d_q       <= d_d;
      ctx_q     <= ctx_d;
      p1_vld_q  <= issue;
      p2_vld_q  <= p1_vld_q;
      done_q    <= p2_vld_q && p2_last_q;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tok_q      <= tok_d;
    head_q     <= head_d;
    max_q      <= max_d;
    sum_q      <= sum_d;
    f_q        <= f_d;
    k_q        <= k_d;
    ez_q       <= ez_d;
    acc_q      <= acc_d;
    p1_first_q <= issue_first;
    p1_last_q  <= issue_last;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    cval_q     <= cval_d;
    dim_q      <= dim_d;
    last_q     <= last_d;
  end

  assign result_valid_o  = res_vld_q;
  assign context_value_o = cval_q;
  assign dim_index_o     = dim_q;
  assign last_o          = last_q;

  // checks
  `CMHA_ASSERT_NEXT(a_last_ends_burst, result_valid_o && last_o, !result_valid_o)
  `CMHA_ASSERT_NEXT(a_compute_goes_busy, comp_ok, busy)
  `CMHA_ASSERT_IMPLY(a_more_results_busy, result_valid_o && !last_o, busy)
  `CMHA_ASSERT_IMPLY(a_sum_nonzero, state_q == S_NRM_DIV, sum_q != '0)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for causal_multihead_attention
// depends on cmha_pkg and the block's rtl; predicts context values independently
`default_nettype none

module tb
  import cmha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTOK     = 256;
  localparam int HDIM     = 64;
  localparam int LOAD_TOK = 2;    // tokens 0..1 loaded on head 0
  localparam int N_RAND   = 6;    // random transactions after the directed ones
  localparam int QUIET    = 20;   // no idling over the last items

  typedef struct packed {
    logic              cmd;
    logic [7:0]        tok;
    logic [7:0]        elem;
    logic [1:0]        head;
    logic signed [15:0] q;
    logic signed [15:0] k;
    logic signed [15:0] v;
  } attn_txn_t;

  typedef struct packed {
    logic signed [15:0] ctx;
    logic [5:0]         dim;
    logic               last;
  } ctx_beat_t;

  logic clk_i, rst_ni, start, busy;
  logic result_valid_o, last_o;
  logic signed [15:0] context_value_o;
  logic [5:0] dim_index_o;
  attn_txn_t cur_txn;

  attn_txn_t txn_queue[$];
  ctx_beat_t ctx_expected[$];
  int        gap_cnt;
  int        err_cnt;

  // shadow copy of the three stores
  shortint q_mem [NTOK*NTOK];
  shortint k_mem [NTOK*NTOK];
  shortint v_mem [NTOK*NTOK];

  causal_multihead_attention u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(cur_txn.cmd), .token_index_i(cur_txn.tok),
    .element_index_i(cur_txn.elem), .head_index_i(cur_txn.head),
    .query_value_i(cur_txn.q), .key_value_i(cur_txn.k), .value_value_i(cur_txn.v),
    .result_valid_o(result_valid_o), .context_value_o(context_value_o),
    .dim_index_o(dim_index_o), .last_o(last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // integer square root, bit by bit
  function automatic longint int_sqrt(input longint x);
    longint r, b;
    r = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // natural exponential, via base 2, of a non-positive score difference, Q16 result
  function automatic longint exp_weight(input longint diff);
    longint y, n, f, p;
    y = (diff * LOG2E_Q16 + 32768) >>> 16;
    n = y >>> 16;
    f = y - n * 65536;
    if (-n > 16) return 0;
    p = 65536 + ((f * (EXP_C1 + ((EXP_C2 * f) >> 16))) >> 16);
    return p >> (-n);
  endfunction

  // full attention for query token t, head h; queues HDIM context beats
  function automatic void predict_context(input int t, input int h);
    longint sc [NTOK];
    longint recip, dot, s, mx, total, acc, c;
    int     base;
    ctx_beat_t b;
    recip = int_sqrt(64'd4294967296 / HDIM);
    base  = h * HDIM;
    for (int j = 0; j <= t; j++) begin
      dot = 0;
      for (int d = 0; d < HDIM; d++)
        dot += longint'(q_mem[t*NTOK + base + d]) * longint'(k_mem[j*NTOK + base + d]);
      s = (dot * recip + 32768) >>> 16;
      if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
      if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
      sc[j] = s;
    end
    mx = sc[0];
    for (int j = 1; j <= t; j++) if (sc[j] > mx) mx = sc[j];
    total = 0;
    for (int j = 0; j <= t; j++) begin
      sc[j] = exp_weight(sc[j] - mx);
      total += sc[j];
    end
    for (int j = 0; j <= t; j++) begin
      sc[j] = ((sc[j] << 16) + total / 2) / total;
      if (sc[j] > 65535) sc[j] = 65535;
    end
    for (int d = 0; d < HDIM; d++) begin
      acc = 0;
      for (int j = 0; j <= t; j++) acc += sc[j] * longint'(v_mem[j*NTOK + base + d]);
      c = (acc + 32768) >>> 16;
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      b.ctx  = c[15:0];
      b.dim  = d[5:0];
      b.last = (d == HDIM - 1);
      ctx_expected.push_back(b);
    end
  endfunction

  // apply one accepted transaction to the shadow state
  function automatic void commit_txn(input attn_txn_t tr);
    int a;
    a = int'(tr.tok) * NTOK + int'(tr.elem);
    if (tr.cmd == CMD_LOAD) begin
      q_mem[a] = tr.q;
      k_mem[a] = tr.k;
      v_mem[a] = tr.v;
    end else begin
      predict_context(int'(tr.tok), int'(tr.head));
    end
  endfunction

  // mixed Q8.8 values: full range, around one, tiny, extremes
  function automatic logic signed [15:0] q88_val();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom());
      1:       return 16'sh7FFF;
      2:       return 16'sh8000;
      3:       return 16'(int'($urandom_range(0, 31)) - 16);
      default: return 16'(int'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  function automatic attn_txn_t mk_load(input int t, input int e);
    attn_txn_t tr;
    tr.cmd  = CMD_LOAD;
    tr.tok  = 8'(t);
    tr.elem = 8'(e);
    tr.head = 2'($urandom());
    tr.q    = q88_val();
    tr.k    = q88_val();
    tr.v    = q88_val();
    return tr;
  endfunction

  function automatic attn_txn_t mk_compute(input int t, input int h);
    attn_txn_t tr;
    tr      = '0;
    tr.cmd  = CMD_COMPUTE;
    tr.tok  = 8'(t);
    tr.head = 2'(h);
    tr.elem = 8'($urandom());
    tr.q    = 16'($urandom());
    tr.k    = 16'($urandom());
    tr.v    = 16'($urandom());
    return tr;
  endfunction

  // stimulus: two tokens on head 0, directed computes, then random traffic
  initial begin
    attn_txn_t tr;
    // single key token: weight saturates at one
    for (int e = 0; e < HDIM; e++) txn_queue.push_back(mk_load(0, e));
    txn_queue.push_back(mk_compute(0, 0));
    // second token with full-scale keys on the lower half
    for (int e = 0; e < HDIM; e++) begin
      tr = mk_load(1, e);
      if (e < HDIM / 2) tr.k = 16'sh7FFF;
      txn_queue.push_back(tr);
    end
    txn_queue.push_back(mk_compute(1, 0));
    txn_queue.push_back(mk_compute(0, 0));
    // random overwrites and computes over the loaded region
    for (int i = 0; i < N_RAND; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        txn_queue.push_back(mk_load($urandom_range(0, LOAD_TOK-1), $urandom_range(0, HDIM-1)));
      end else begin
        txn_queue.push_back(mk_compute($urandom_range(0, LOAD_TOK-1), 0));
      end
    end
  end

  // driver: present next transaction, hold until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    automatic logic fire;
    if (!rst_ni) begin
      start   <= 1'b0;
      cur_txn <= '0;
      gap_cnt <= 0;
    end else begin
      fire = start && !busy;
      if (fire) commit_txn(cur_txn);
      if (start && !fire) begin
        start <= 1'b1;
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start   <= 1'b0;
      end else if (txn_queue.size() > 0) begin
        cur_txn <= txn_queue.pop_front();
        start   <= 1'b1;
        if (txn_queue.size() > QUIET && $urandom_range(0, 4) == 0)
          gap_cnt <= $urandom_range(1, 14);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    automatic ctx_beat_t exp_b;
    if (rst_ni && result_valid_o) begin
      if (ctx_expected.size() == 0) begin
        $display("%0t: unexpected result ctx=%0d dim=%0d last=%0b",
                 $realtime, context_value_o, dim_index_o, last_o);
        err_cnt++;
      end else begin
        exp_b = ctx_expected.pop_front();
        if (exp_b.ctx !== context_value_o) begin
          $display("%0t: context_value expected %0d actual %0d",
                   $realtime, exp_b.ctx, context_value_o);
          err_cnt++;
        end
        if (exp_b.dim !== dim_index_o) begin
          $display("%0t: dim_index expected %0d actual %0d",
                   $realtime, exp_b.dim, dim_index_o);
          err_cnt++;
        end
        if (exp_b.last !== last_o) begin
          $display("%0t: last expected %0b actual %0b", $realtime, exp_b.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  // reset, then wait for the stimulus and results to drain
  initial begin
    rst_ni  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (txn_queue.size() > 0 || start) @(posedge clk_i);
    while (ctx_expected.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (ctx_expected.size() == 0 && err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
